[rtl/ihex_pkg.sv]
// Types, codes and helpers shared by the Intel HEX record parser.
// No dependencies.
`timescale 1ns / 1ps

package ihex_pkg;

  typedef enum logic [3:0] {
    PH_LINE  = 4'd0,
    PH_LEN   = 4'd1,
    PH_AHI   = 4'd2,
    PH_ALO   = 4'd3,
    PH_TYPE  = 4'd4,
    PH_DATA  = 4'd5,
    PH_CHECK = 4'd6,
    PH_TAIL  = 4'd7,
    PH_SKIP  = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    K_DATA   = 3'd0,
    K_CSUM   = 3'd1,
    K_INVAL  = 3'd2,
    K_EXCESS = 3'd3,
    K_NOEND  = 3'd4,
    K_END    = 3'd5
  } kind_t;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [7:0] REC_DATA = 8'd0;
  localparam logic [7:0] REC_EOF  = 8'd1;

  typedef struct packed {
    logic       none;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_digit(input logic [7:0] c);
    hex_digit_t d;
    d.none  = 1'b0;
    d.value = 4'd0;
    if (c inside {["0":"9"]}) begin
      d.value = 4'(c - 8'h30);
    end else if (c inside {["a":"f"]}) begin
      d.value = 4'(c - 8'h57);
    end else if (c inside {["A":"F"]}) begin
      d.value = 4'(c - 8'h37);
    end else begin
      d.none = 1'b1;
    end
    return d;
  endfunction

  function automatic logic is_nl(input logic [7:0] c);
    return (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_sp(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

endpackage

[rtl/intel_hex_record_parser.sv]
// Intel HEX record parser: one text character in, at most one result word out.
// Depends on ihex_pkg.
//
// channel | dir | ports                       | contents
// in      | in  | in_tvalid/tready/tdata      | tdata[7:0] ch
// out     | out | out_tvalid/tready/tdata     | tdata: data_byte, record_address,
//         |     | out_tuser, out_tlast        |   byte_index; tuser kind; tlast finished
//
// One character per cycle unless out_tready stalls it; input register, then result register.
// The parse state updates in the single step from the input register to the result register.
// Reset is synchronous, active low, and takes effect at once: no clearing pass.
// A stalled result register holds the input register, which then holds in_tready low.
// After an end record or a zero character all further characters are taken and dropped.
`timescale 1ns / 1ps

module intel_hex_record_parser
  import ihex_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] data_byte, [23:8] record_address, [31:24] byte_index
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast   // finished
);

  logic        in_vld_r;
  logic [7:0]  ch_r;
  logic        step;

  phase_t      phase_r, phase_nxt;
  logic        second_r, second_nxt;
  logic [3:0]  high_r, high_nxt;
  logic [7:0]  rec_len_r, rec_len_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  rec_type_r, rec_type_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        stopped_r, stopped_nxt;

  logic        emit;
  kind_t       kind;
  logic [7:0]  data_byte;
  logic [7:0]  byte_index;
  logic        finished;

  hex_digit_t  dig;
  logic [7:0]  pair;
  logic        csum_bad;

  logic        out_vld_r;
  kind_t       out_kind_r;
  logic [7:0]  out_data_r;
  logic [15:0] out_addr_r;
  logic [7:0]  out_idx_r;
  logic        out_fin_r;

  assign step      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      ch_r <= in_tdata;
    end
  end

  assign dig      = hex_digit(ch_r);
  assign pair     = {high_r, dig.value};
  assign csum_bad = (8'd0 - sum_r) != pair;

  always_comb begin
    phase_nxt    = phase_r;
    second_nxt   = second_r;
    high_nxt     = high_r;
    rec_len_nxt  = rec_len_r;
    left_nxt     = left_r;
    addr_nxt     = addr_r;
    rec_type_nxt = rec_type_r;
    sum_nxt      = sum_r;
    stopped_nxt  = stopped_r;
    if (stopped_r) begin
      stopped_nxt = 1'b1;
    end else if (ch_r == CH_NUL) begin
      stopped_nxt = 1'b1;
    end else begin
      case (phase_r)
        PH_LINE: begin
          if (is_sp(ch_r) || is_nl(ch_r)) begin
            phase_nxt = PH_LINE;
          end else if (ch_r != CH_COLON) begin
            phase_nxt = PH_SKIP;
          end else begin
            sum_nxt    = 8'd0;
            second_nxt = 1'b0;
            phase_nxt  = PH_LEN;
          end
        end
        PH_TAIL: begin
          if (is_nl(ch_r)) begin
            phase_nxt = PH_LINE;
          end else if (!is_sp(ch_r)) begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (is_nl(ch_r)) begin
            phase_nxt = PH_LINE;
          end
        end
        PH_LEN, PH_AHI, PH_ALO, PH_TYPE, PH_DATA, PH_CHECK: begin
          if (dig.none) begin
            second_nxt = 1'b0;
            phase_nxt  = is_nl(ch_r) ? PH_LINE : PH_SKIP;
          end else if (!second_r) begin
            high_nxt   = dig.value;
            second_nxt = 1'b1;
          end else begin
            second_nxt = 1'b0;
            case (phase_r)
              PH_LEN: begin
                rec_len_nxt = pair;
                sum_nxt     = sum_r + pair;
                phase_nxt   = PH_AHI;
              end
              PH_AHI: begin
                addr_nxt  = {pair, 8'd0};
                sum_nxt   = sum_r + pair;
                phase_nxt = PH_ALO;
              end
              PH_ALO: begin
                addr_nxt  = {addr_r[15:8], pair};
                sum_nxt   = sum_r + pair;
                phase_nxt = PH_TYPE;
              end
              PH_TYPE: begin
                rec_type_nxt = pair;
                sum_nxt      = sum_r + pair;
                if (pair > REC_EOF) begin
                  phase_nxt = PH_SKIP;
                end else begin
                  left_nxt  = rec_len_r;
                  phase_nxt = (rec_len_r != 8'd0) ? PH_DATA : PH_CHECK;
                end
              end
              PH_DATA: begin
                sum_nxt   = sum_r + pair;
                left_nxt  = left_r - 8'd1;
                phase_nxt = (left_r != 8'd1) ? PH_DATA : PH_CHECK;
              end
              default: begin
                if (rec_type_r == REC_EOF) begin
                  stopped_nxt = 1'b1;
                end else begin
                  phase_nxt = PH_TAIL;
                end
              end
            endcase
          end
        end
        default: begin
          phase_nxt = PH_SKIP;
        end
      endcase
    end
  end

  always_comb begin
    emit       = 1'b0;
    kind       = K_DATA;
    data_byte  = 8'd0;
    byte_index = 8'd0;
    finished   = 1'b0;
    if (!stopped_r) begin
      if (ch_r == CH_NUL) begin
        emit     = 1'b1;
        kind     = K_NOEND;
        finished = 1'b1;
      end else begin
        case (phase_r)
          PH_LINE: begin
            if (!is_sp(ch_r) && !is_nl(ch_r) && ch_r != CH_COLON) begin
              emit = 1'b1;
              kind = K_INVAL;
            end
          end
          PH_TAIL: begin
            if (!is_nl(ch_r) && !is_sp(ch_r)) begin
              emit = 1'b1;
              kind = K_EXCESS;
            end
          end
          PH_LEN, PH_AHI, PH_ALO, PH_TYPE, PH_DATA, PH_CHECK: begin
            if (dig.none) begin
              emit = 1'b1;
              kind = K_INVAL;
            end else if (second_r) begin
              case (phase_r)
                PH_TYPE: begin
                  if (pair > REC_EOF) begin
                    emit = 1'b1;
                    kind = K_INVAL;
                  end
                end
                PH_DATA: begin
                  if (rec_type_r == REC_DATA) begin
                    emit       = 1'b1;
                    kind       = K_DATA;
                    data_byte  = pair;
                    byte_index = rec_len_r - left_r;
                  end
                end
                PH_CHECK: begin
                  emit     = (rec_type_r == REC_EOF) || csum_bad;
                  kind     = csum_bad ? K_CSUM : K_END;
                  finished = (rec_type_r == REC_EOF);
                end
                default: begin
                  emit = 1'b0;
                end
              endcase
            end
          end
          default: begin
            emit = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_LINE;
      second_r   <= 1'b0;
      high_r     <= 4'd0;
      rec_len_r  <= 8'd0;
      left_r     <= 8'd0;
      addr_r     <= 16'd0;
      rec_type_r <= 8'd0;
      sum_r      <= 8'd0;
      stopped_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (step) begin
        phase_r    <= phase_nxt;
        second_r   <= second_nxt;
        high_r     <= high_nxt;
        rec_len_r  <= rec_len_nxt;
        left_r     <= left_nxt;
        addr_r     <= addr_nxt;
        rec_type_r <= rec_type_nxt;
        sum_r      <= sum_nxt;
        stopped_r  <= stopped_nxt;
      end
      if (step) begin
        out_vld_r <= emit;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_kind_r <= kind;
      out_data_r <= data_byte;
      out_addr_r <= addr_nxt;
      out_idx_r  <= byte_index;
      out_fin_r  <= finished;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_idx_r, out_addr_r, out_data_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_fin_r;

  a_quiet_after_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (stopped_r && !out_vld_r) |=> !out_vld_r)
    else $error("result word after parsing stopped");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_fin_r) |->
      (out_kind_r == K_NOEND || out_kind_r == K_END || out_kind_r == K_CSUM))
    else $error("finished word with wrong kind");

  a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_fin_r) |-> stopped_r)
    else $error("finished word but parser still running");

  a_data_type: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_kind_r == K_DATA) |-> (rec_type_r == REC_DATA && !out_fin_r))
    else $error("data word outside a data record");

  a_digit_phase: assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> (phase_r == PH_LEN || phase_r == PH_AHI || phase_r == PH_ALO ||
                  phase_r == PH_TYPE || phase_r == PH_DATA || phase_r == PH_CHECK))
    else $error("half digit pair outside a record field");

endmodule
